FILE: rtl/gradient_noise_3d_macros.svh
// ----------------------------------------------------------------------------
// gradient_noise_3d assertion macros
// Concurrent check helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_MACROS_SVH
`define GRADIENT_NOISE_3D_MACROS_SVH
`ifndef SYNTHESIS
`define GN3D_ASSERT_NOW(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gradient_noise_3d: check failed");
`define GN3D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gradient_noise_3d: check failed");
`else
`define GN3D_ASSERT_NOW(lbl, clk, rst, expr)
`define GN3D_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/gn3d_pkg.sv
// ----------------------------------------------------------------------------
// gn3d_pkg
// Constants, permutation table and gradient selection for gradient_noise_3d.
// ----------------------------------------------------------------------------
`default_nettype none
package gn3d_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 16;
  localparam int INT_W     = 8;
  localparam int OUT_W     = 18;
  localparam int VAL_W     = FRAC_BITS + 2;   // signed fraction or offset
  localparam int GRAD_W    = VAL_W + 1;
  localparam int LERP_W    = VAL_W + 2;
  localparam int DIFF_W    = LERP_W + 1;
  localparam int INNER_W   = FRAC_BITS + 5;
  localparam int LAT       = 10;

  localparam logic signed [INNER_W-1:0] ONE_I   = INNER_W'(1) <<< FRAC_BITS;
  localparam logic signed [INNER_W-1:0] FIFT_I  = INNER_W'(15) <<< FRAC_BITS;
  localparam logic signed [INNER_W-1:0] TEN_I   = INNER_W'(10) <<< FRAC_BITS;
  localparam logic signed [VAL_W-1:0]   ONE_V   = VAL_W'(1) <<< FRAC_BITS;
  localparam logic signed [OUT_W-1:0]   OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0]   OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // gradient pattern codes
  localparam logic [3:0] H_USE_Y  = 4'd8;
  localparam logic [3:0] H_K_Y    = 4'd4;
  localparam logic [3:0] H_K_XA   = 4'd12;
  localparam logic [3:0] H_K_XB   = 4'd14;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic signed [GRAD_W-1:0] grad(
    input logic [7:0]              h,
    input logic signed [VAL_W-1:0] x,
    input logic signed [VAL_W-1:0] y,
    input logic signed [VAL_W-1:0] z
  );
    logic [3:0] h4;
    logic signed [GRAD_W-1:0] g;
    logic signed [GRAD_W-1:0] k;
    h4 = h[3:0];
    g  = (h4 < H_USE_Y) ? GRAD_W'(x) : GRAD_W'(y);
    if (h4 < H_K_Y) begin
      k = GRAD_W'(y);
    end else if (h4 == H_K_XA || h4 == H_K_XB) begin
      k = GRAD_W'(x);
    end else begin
      k = GRAD_W'(z);
    end
    if (h4[0]) g = -g;
    if (h4[1]) k = -k;
    return g + k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gradient_noise_3d.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d
// 3D improved gradient noise, Q8.16 coordinates in, Q2.16 noise out.
// ----------------------------------------------------------------------------
// A point is transferred when start is high; busy is always low, so one point
// can enter every clock. The result appears on noise_value with done high for
// exactly one cycle, in entry order. The pipeline has three multiply stages for
// the fade curve (in parallel with three permutation lookups), one gradient
// stage, and two multiply/add stages for each of the x, y and z blends.
`default_nettype none
module gradient_noise_3d
  import gn3d_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [COORD_W-1:0]      coord_x,
  input  wire logic [COORD_W-1:0]      coord_y,
  input  wire logic [COORD_W-1:0]      coord_z,
  output logic                         done,
  output logic signed [OUT_W-1:0]      noise_value
);

  `include "gradient_noise_3d_macros.svh"

  logic [LAT-1:0] vld;

  // stage 1
  logic [FRAC_BITS-1:0]           s1_t  [3];
  logic [FRAC_BITS-1:0]           s1_t2 [3];
  logic signed [INNER_W-1:0]      s1_pf [3];
  logic [INT_W-1:0]               s1_a, s1_b, s1_iz;
  // stage 2
  logic [FRAC_BITS-1:0]           s2_t  [3];
  logic [FRAC_BITS-1:0]           s2_t3 [3];
  logic signed [INNER_W-1:0]      s2_in [3];
  logic [INT_W-1:0]               s2_hh [4];
  // stage 3
  logic [FRAC_BITS-1:0]           s3_t  [3];
  logic signed [VAL_W-1:0]        s3_f  [3];
  logic [7:0]                     s3_h  [8];
  // stage 4
  logic signed [GRAD_W-1:0]       s4_g  [8];
  logic signed [VAL_W-1:0]        s4_f  [3];
  // stage 5/6
  logic signed [GRAD_W-1:0]       s5_a  [4];
  logic signed [DIFF_W+VAL_W-1:0] s5_p  [4];
  logic signed [VAL_W-1:0]        s5_vw [2];
  logic signed [LERP_W-1:0]       s6_l  [4];
  logic signed [VAL_W-1:0]        s6_vw [2];
  // stage 7/8
  logic signed [LERP_W-1:0]       s7_a  [2];
  logic signed [DIFF_W+VAL_W-1:0] s7_p  [2];
  logic signed [VAL_W-1:0]        s7_w;
  logic signed [LERP_W-1:0]       s8_l  [2];
  logic signed [VAL_W-1:0]        s8_w;
  // stage 9
  logic signed [LERP_W-1:0]       s9_a;
  logic signed [DIFF_W+VAL_W-1:0] s9_p;

  logic [FRAC_BITS-1:0] in_t [3];
  logic [INT_W-1:0]     ix, iy, iz;
  logic signed [DIFF_W+VAL_W-1:0] fin;

  assign busy = 1'b0;
  assign in_t[0] = coord_x[FRAC_BITS-1:0];
  assign in_t[1] = coord_y[FRAC_BITS-1:0];
  assign in_t[2] = coord_z[FRAC_BITS-1:0];
  assign ix = coord_x[COORD_W-1 -: INT_W];
  assign iy = coord_y[COORD_W-1 -: INT_W];
  assign iz = coord_z[COORD_W-1 -: INT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  // fade curve and hash chain
  always_ff @(posedge clk) begin
    logic signed [INNER_W-1:0]         q;
    logic signed [INNER_W+VAL_W-1:0]   m;
    logic [2*FRAC_BITS-1:0]            sq;
    for (int i = 0; i < 3; i++) begin
      q  = INNER_W'(6) * $signed({5'b0, in_t[i]}) - FIFT_I;
      m  = $signed({2'b0, in_t[i]}) * q;
      sq = in_t[i] * in_t[i];
      s1_t[i]  <= in_t[i];
      s1_t2[i] <= sq[2*FRAC_BITS-1:FRAC_BITS];
      s1_pf[i] <= INNER_W'(m >>> FRAC_BITS);

      sq = s1_t2[i] * s1_t[i];
      s2_t[i]  <= s1_t[i];
      s2_t3[i] <= sq[2*FRAC_BITS-1:FRAC_BITS];
      s2_in[i] <= s1_pf[i] + TEN_I;

      m  = $signed({2'b0, s2_t3[i]}) * s2_in[i];
      s3_t[i] <= s2_t[i];
      s3_f[i] <= VAL_W'(m >>> FRAC_BITS);
    end
    s1_a  <= PERM[ix] + iy;
    s1_b  <= PERM[ix + 8'd1] + iy;
    s1_iz <= iz;
    s2_hh[0] <= PERM[s1_a] + s1_iz;          // aa
    s2_hh[1] <= PERM[s1_b] + s1_iz;          // ba
    s2_hh[2] <= PERM[s1_a + 8'd1] + s1_iz;   // ab
    s2_hh[3] <= PERM[s1_b + 8'd1] + s1_iz;   // bb
    for (int c = 0; c < 4; c++) begin
      s3_h[c]     <= PERM[s2_hh[c]];
      s3_h[c + 4] <= PERM[s2_hh[c] + 8'd1];
    end
  end

  // gradients and blends; corner index bits are {z, y, x}
  always_ff @(posedge clk) begin
    logic signed [VAL_W-1:0]  cx, cy, cz;
    logic signed [DIFF_W-1:0] d;
    for (int c = 0; c < 8; c++) begin
      cx = $signed({2'b0, s3_t[0]}) - (c[0] ? ONE_V : VAL_W'(0));
      cy = $signed({2'b0, s3_t[1]}) - (c[1] ? ONE_V : VAL_W'(0));
      cz = $signed({2'b0, s3_t[2]}) - (c[2] ? ONE_V : VAL_W'(0));
      s4_g[c] <= grad(s3_h[c], cx, cy, cz);
    end
    s4_f <= s3_f;

    for (int i = 0; i < 4; i++) begin
      d = DIFF_W'(s4_g[2*i+1]) - DIFF_W'(s4_g[2*i]);
      s5_a[i] <= s4_g[2*i];
      s5_p[i] <= s4_f[0] * d;
      s6_l[i] <= LERP_W'(s5_a[i]) + LERP_W'(s5_p[i] >>> FRAC_BITS);
    end
    s5_vw[0] <= s4_f[1];
    s5_vw[1] <= s4_f[2];
    s6_vw    <= s5_vw;

    for (int j = 0; j < 2; j++) begin
      d = DIFF_W'(s6_l[2*j+1]) - DIFF_W'(s6_l[2*j]);
      s7_a[j] <= s6_l[2*j];
      s7_p[j] <= s6_vw[0] * d;
      s8_l[j] <= s7_a[j] + LERP_W'(s7_p[j] >>> FRAC_BITS);
    end
    s7_w <= s6_vw[1];
    s8_w <= s7_w;

    d = DIFF_W'(s8_l[1]) - DIFF_W'(s8_l[0]);
    s9_a <= s8_l[0];
    s9_p <= s8_w * d;

    if (fin > (DIFF_W+VAL_W)'(OUT_MAX)) begin
      noise_value <= OUT_MAX;
    end else if (fin < (DIFF_W+VAL_W)'(OUT_MIN)) begin
      noise_value <= OUT_MIN;
    end else begin
      noise_value <= OUT_W'(fin);
    end
  end

  assign fin  = (DIFF_W+VAL_W)'(s9_a) + (s9_p >>> FRAC_BITS);
  assign done = vld[LAT-1];

  `GN3D_ASSERT_NOW(a_never_busy, clk, rst, !busy)
  `GN3D_ASSERT_NEXT(a_enter, clk, rst, start, vld[0])
  `GN3D_ASSERT_NOW(a_fade_range, clk, rst, !vld[2] || (s3_f[0] >= 0 && s3_f[0] <= ONE_V))

endmodule
`default_nettype wire
